@@ hw/rtl/fcrp_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the cell walk block.
`default_nettype none
package fcrp_pkg;

  localparam int NODES      = 32;
  localparam int MAX_DEG    = 4;
  localparam int CELL_W     = 5;
  localparam int CFG_W      = 6;
  localparam int SLOT_W     = $clog2(MAX_DEG + 1);
  localparam int SLOT_IDX_W = (MAX_DEG > 1) ? $clog2(MAX_DEG) : 1;
  localparam int TBL_DEPTH  = NODES * MAX_DEG;
  localparam int TBL_AW     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int STACK_CAP  = NODES + 1;
  localparam int STK_AW     = $clog2(STACK_CAP);
  localparam int DEPTH_W    = $clog2(STACK_CAP + 1);
  localparam int CNT_W      = $clog2(NODES + 1);
  localparam int FRAME_W    = CELL_W + SLOT_W;

  typedef enum logic [1:0] {
    ACT_WR_SLOT = 2'd0,
    ACT_SET_OCC = 2'd1,
    ACT_LIST    = 2'd2,
    ACT_MOVE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_CELL = 2'd0,
    ST_NONE = 2'd1,
    ST_ACK  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_ACK,
    EM_FAIL,
    EM_PENDING,
    EM_PATH
  } emit_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RESP_ACK,
    S_RESP_FAIL,
    S_WSTEP,
    S_WEVAL,
    S_WPOPLD,
    S_WDONE,
    S_TRACE,
    S_EMIT_LAST,
    S_EMIT_PATH
  } state_e;

  typedef struct packed {
    logic  capture;
    logic  do_write;
    logic  init_list;
    logic  init_parent;
    logic  fetch;
    logic  eval;
    logic  pop;
    logic  pop_load;
    logic  set_tgt_occ;
    logic  trace_init;
    logic  trace_step;
    logic  clr_start_occ;
    emit_e emit;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic is_list;
    logic bad_start;
    logic depth_zero;
    logic slot_done;
    logic pop_load_req;
    logic eval_stall;
    logic out_free;
    logic walk_parent;
    logic pending_valid;
    logic move_fail;
    logic trace_done;
    logic path_empty;
    logic path_last;
  } stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/fcrp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fcrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/fcrp_ctrl.sv @@
// Sequencer for writes, the listing walk, the parent walk, path trace and result words.
`default_nettype none
module fcrp_ctrl import fcrp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.emit = EM_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_write) begin
          cmd_o.do_write = 1'b1;
          state_d        = S_RESP_ACK;
        end else if (stat_i.bad_start) begin
          state_d = S_RESP_FAIL;
        end else begin
          cmd_o.init_list = 1'b1;
          state_d         = S_WSTEP;
        end
      end
      S_RESP_ACK: begin
        if (stat_i.out_free) begin
          cmd_o.emit = EM_ACK;
          state_d    = S_IDLE;
        end
      end
      S_RESP_FAIL: begin
        if (stat_i.out_free) begin
          cmd_o.emit = EM_FAIL;
          state_d    = S_IDLE;
        end
      end
      S_WSTEP: begin
        if (stat_i.depth_zero) begin
          state_d = S_WDONE;
        end else if (stat_i.slot_done) begin
          cmd_o.pop = 1'b1;
          if (stat_i.pop_load_req) begin
            state_d = S_WPOPLD;
          end
        end else begin
          cmd_o.fetch = 1'b1;
          state_d     = S_WEVAL;
        end
      end
      S_WEVAL: begin
        if (!stat_i.eval_stall) begin
          cmd_o.eval = 1'b1;
          state_d    = S_WSTEP;
        end
      end
      S_WPOPLD: begin
        cmd_o.pop_load = 1'b1;
        state_d        = S_WSTEP;
      end
      S_WDONE: begin
        if (stat_i.walk_parent) begin
          cmd_o.trace_init = 1'b1;
          state_d          = S_TRACE;
        end else if (stat_i.is_list) begin
          state_d = stat_i.pending_valid ? S_EMIT_LAST : S_RESP_FAIL;
        end else if (stat_i.move_fail) begin
          state_d = S_RESP_FAIL;
        end else begin
          cmd_o.set_tgt_occ = 1'b1;
          cmd_o.init_parent = 1'b1;
          state_d           = S_WSTEP;
        end
      end
      S_TRACE: begin
        if (stat_i.trace_done) begin
          cmd_o.clr_start_occ = 1'b1;
          state_d = stat_i.path_empty ? S_IDLE : S_EMIT_PATH;
        end else begin
          cmd_o.trace_step = 1'b1;
        end
      end
      S_EMIT_LAST: begin
        if (stat_i.out_free) begin
          cmd_o.emit = EM_PENDING;
          state_d    = S_IDLE;
        end
      end
      S_EMIT_PATH: begin
        if (stat_i.out_free) begin
          cmd_o.emit = EM_PATH;
          if (stat_i.path_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/fcrp_dp.sv @@
// Datapath: graph storage, walk stack, visited/occupied bits, parent trace and result register.
`default_nettype none
module fcrp_dp import fcrp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output stat_t                  stat_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic [1:0]        action_i,
  input  wire logic [CELL_W-1:0] cell_req_i,
  input  wire logic [1:0]        slot_i,
  input  wire logic [CELL_W-1:0] neighbour_cell_i,
  input  wire logic              flag_i,
  input  wire logic [CELL_W-1:0] target_cell_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [CELL_W-1:0]      cell_out_o,
  output logic [1:0]             status_o,
  output logic                   last_o
);

  // captured input word
  action_e           act_q;
  logic [CELL_W-1:0] cell_q, nbc_q, tgt_q;
  logic [1:0]        slot_q;
  logic              flag_q;

  logic [CFG_W-1:0]  cfg_q;
  logic [CFG_W-1:0]  n_live;

  logic [NODES-1:0]  occ_q, vis_q;
  logic [TBL_DEPTH-1:0] written_q;
  logic              written_rd_q;

  logic [CELL_W-1:0] top_cell_q;
  logic [SLOT_W-1:0] top_slot_q;
  logic [DEPTH_W-1:0] depth_q;
  logic              walk_parent_q;

  logic [CELL_W-1:0] pend_q;
  logic              pend_valid_q;

  logic [CELL_W-1:0] parent_q [NODES];
  logic [CELL_W-1:0] path_q   [NODES];
  logic [CELL_W-1:0] trace_q;
  logic [CNT_W-1:0]  cnt_q;

  logic              out_valid_q, out_last_q;
  logic [CELL_W-1:0] out_cell_q;
  status_e           out_status_q;

  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic              tbl_we;
  logic [CELL_W:0]   tbl_rdata;
  logic              stk_we;
  logic [FRAME_W-1:0] stk_rdata;
  logic [STK_AW-1:0] stk_waddr, stk_raddr;

  logic              out_free, entry_ok, cand, push_ok, do_push, list_emit;
  logic [CELL_W-1:0] nb;

  always_comb begin
    if (cfg_q == '0) begin
      n_live = CFG_W'(1);
    end else if (cfg_q > CFG_W'(NODES)) begin
      n_live = CFG_W'(NODES);
    end else begin
      n_live = cfg_q;
    end
  end

  assign tbl_waddr = TBL_AW'(32'(cell_q) * MAX_DEG + 32'(slot_q));
  assign tbl_raddr = TBL_AW'(32'(top_cell_q) * MAX_DEG + 32'(top_slot_q[SLOT_IDX_W-1:0]));
  assign tbl_we    = cmd_i.do_write && (act_q == ACT_WR_SLOT) &&
                     ({1'b0, cell_q} < n_live) && (32'(slot_q) < MAX_DEG);

  fcrp_ram #(.WIDTH(CELL_W + 1), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i ({flag_q, nbc_q}),
    .re_i    (cmd_i.fetch),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // slot entries never written read as invalid
  assign nb       = tbl_rdata[CELL_W-1:0];
  assign entry_ok = written_rd_q && tbl_rdata[CELL_W] && ({1'b0, nb} < n_live);
  assign cand     = walk_parent_q ? (entry_ok && !vis_q[nb])
                                  : (entry_ok && !occ_q[nb] && !vis_q[nb]);
  assign push_ok  = !walk_parent_q || !(occ_q[nb] && (nb != cell_q));
  assign do_push  = cmd_i.eval && cand && push_ok && (depth_q < DEPTH_W'(STACK_CAP));
  // only a listing reports the cells it reaches
  assign list_emit = cmd_i.eval && cand && !walk_parent_q && (act_q == ACT_LIST) &&
                     pend_valid_q;

  // the frame below the new top is spilled to the stack memory
  assign stk_we    = do_push && (depth_q != '0);
  assign stk_waddr = STK_AW'(depth_q - DEPTH_W'(1));
  assign stk_raddr = STK_AW'(depth_q - DEPTH_W'(2));

  fcrp_ram #(.WIDTH(FRAME_W), .DEPTH(STACK_CAP)) u_stk (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i ({top_cell_q, top_slot_q}),
    .re_i    (cmd_i.pop),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_e'(action_i);
      cell_q <= cell_req_i;
      slot_q <= slot_i;
      nbc_q  <= neighbour_cell_i;
      flag_q <= flag_i;
      tgt_q  <= target_cell_i;
    end
    if (cmd_i.fetch) begin
      written_rd_q <= written_q[tbl_raddr];
    end
    if (cmd_i.init_list || cmd_i.init_parent) begin
      top_cell_q <= cell_q;
      top_slot_q <= '0;
    end else if (cmd_i.fetch) begin
      top_slot_q <= top_slot_q + SLOT_W'(1);
    end else if (do_push) begin
      top_cell_q <= nb;
      top_slot_q <= '0;
    end else if (cmd_i.pop_load) begin
      {top_cell_q, top_slot_q} <= stk_rdata;
    end
    if (cmd_i.init_parent) begin
      parent_q[cell_q] <= cell_q;
    end else if (cmd_i.eval && cand && walk_parent_q) begin
      parent_q[nb] <= top_cell_q;
    end
    if (cmd_i.eval && cand && !walk_parent_q) begin
      pend_q <= nb;
    end
    if (cmd_i.trace_init) begin
      trace_q <= tgt_q;
    end else if (cmd_i.trace_step) begin
      path_q[cnt_q[CELL_W-1:0]] <= trace_q;
      trace_q <= parent_q[trace_q];
    end
    if (list_emit) begin
      out_cell_q   <= pend_q;
      out_status_q <= ST_CELL;
      out_last_q   <= 1'b0;
    end else begin
      case (cmd_i.emit)
        EM_ACK: begin
          out_cell_q   <= '0;
          out_status_q <= ST_ACK;
          out_last_q   <= 1'b1;
        end
        EM_FAIL: begin
          out_cell_q   <= '0;
          out_status_q <= ST_NONE;
          out_last_q   <= 1'b1;
        end
        EM_PENDING: begin
          out_cell_q   <= pend_q;
          out_status_q <= ST_CELL;
          out_last_q   <= 1'b1;
        end
        EM_PATH: begin
          out_cell_q   <= path_q[CELL_W'(cnt_q - CNT_W'(1))];
          out_status_q <= ST_CELL;
          out_last_q   <= (cnt_q == CNT_W'(1));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q         <= CFG_W'(32);
      occ_q         <= '0;
      vis_q         <= '0;
      written_q     <= '0;
      depth_q       <= '0;
      walk_parent_q <= 1'b0;
      pend_valid_q  <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (tbl_we) begin
        written_q[tbl_waddr] <= 1'b1;
      end
      if (cmd_i.do_write && (act_q == ACT_SET_OCC) && ({1'b0, cell_q} < n_live)) begin
        occ_q[cell_q] <= flag_q;
      end
      if (cmd_i.set_tgt_occ) begin
        occ_q[tgt_q] <= 1'b1;
      end
      if (cmd_i.clr_start_occ) begin
        occ_q[cell_q] <= 1'b0;
      end
      if (cmd_i.init_list) begin
        vis_q         <= '0;
        walk_parent_q <= 1'b0;
        pend_valid_q  <= 1'b0;
        depth_q       <= DEPTH_W'(1);
      end else if (cmd_i.init_parent) begin
        vis_q         <= NODES'(1) << cell_q;
        walk_parent_q <= 1'b1;
        depth_q       <= DEPTH_W'(1);
      end else begin
        if (cmd_i.eval && cand) begin
          vis_q[nb] <= 1'b1;
          if (!walk_parent_q) begin
            pend_valid_q <= 1'b1;
          end
        end
        if (do_push) begin
          depth_q <= depth_q + DEPTH_W'(1);
        end else if (cmd_i.pop) begin
          depth_q <= depth_q - DEPTH_W'(1);
        end
      end
      if (cmd_i.trace_init) begin
        cnt_q <= '0;
      end else if (cmd_i.trace_step) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.emit == EM_PATH) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (list_emit || (cmd_i.emit != EM_NONE)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.is_write      = (act_q == ACT_WR_SLOT) || (act_q == ACT_SET_OCC);
    stat_o.is_list       = (act_q == ACT_LIST);
    stat_o.bad_start     = !({1'b0, cell_q} < n_live);
    stat_o.depth_zero    = (depth_q == '0);
    stat_o.slot_done     = (32'(top_slot_q) >= MAX_DEG);
    stat_o.pop_load_req  = (depth_q > DEPTH_W'(1));
    stat_o.eval_stall    = cand && !walk_parent_q && (act_q == ACT_LIST) && pend_valid_q &&
                           !out_free;
    stat_o.out_free      = out_free;
    stat_o.walk_parent   = walk_parent_q;
    stat_o.pending_valid = pend_valid_q;
    stat_o.move_fail     = !({1'b0, tgt_q} < n_live) || (tgt_q == cell_q) || !vis_q[tgt_q];
    stat_o.trace_done    = (trace_q == cell_q) || (cnt_q == CNT_W'(NODES));
    stat_o.path_empty    = (cnt_q == '0);
    stat_o.path_last     = (cnt_q == CNT_W'(1));
  end

  assign out_valid_o = out_valid_q;
  assign cell_out_o  = out_cell_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

endmodule
`default_nettype wire

@@ hw/rtl/free_cell_reach_and_path.sv @@
// Slot/occupancy writes pass the decode and acknowledge states and register their ack word.
// A walk examines each neighbour slot in a fetch step and an evaluate step, as the neighbour
// table read is registered; a popped frame is reloaded from the stack in a load step.
// A move runs two walks, traces the path, then sends one word per cycle unless stalled.
// One word in flight at a time; the next word is taken once the last result is queued.
// Reset (async, active low) frees all cells, invalidates all slots, sets 32 cells in use.
`default_nettype none
module free_cell_reach_and_path import fcrp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        action_i,
  input  wire logic [CELL_W-1:0] cell_req_i,
  input  wire logic [1:0]        slot_i,
  input  wire logic [CELL_W-1:0] neighbour_cell_i,
  input  wire logic              flag_i,
  input  wire logic [CELL_W-1:0] target_cell_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [CELL_W-1:0]      cell_out_o,
  output logic [1:0]             status_o,
  output logic                   last_o
);

  cmd_t  cmd;
  stat_t stat;

  fcrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fcrp_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .action_i         (action_i),
    .cell_req_i       (cell_req_i),
    .slot_i           (slot_i),
    .neighbour_cell_i (neighbour_cell_i),
    .flag_i           (flag_i),
    .target_cell_i    (target_cell_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cell_out_o       (cell_out_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

@@ hw/rtl/fcrp_checker.sv @@
// Port-level checks for the cell walk block, bound to the top level.
`default_nettype none
module fcrp_checker import fcrp_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              cfg_we_i,
  input wire logic [CFG_W-1:0]  cfg_wdata_i,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic [1:0]        action_i,
  input wire logic [CELL_W-1:0] cell_req_i,
  input wire logic [1:0]        slot_i,
  input wire logic [CELL_W-1:0] neighbour_cell_i,
  input wire logic              flag_i,
  input wire logic [CELL_W-1:0] target_cell_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [CELL_W-1:0] cell_out_o,
  input wire logic [1:0]        status_o,
  input wire logic              last_o
);

  // one word at a time: after an accept the input side closes
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted on consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(cell_out_o) &&
      $stable(status_o) && $stable(last_o)))
    else $error("stalled result word changed");

  a_zero_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_CELL)) |-> (cell_out_o == '0))
    else $error("cell field not zero on non-cell status");

  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((status_o == ST_ACK) || (status_o == ST_NONE))) |-> last_o)
    else $error("ack or empty result not marked last");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == ST_CELL) || (status_o == ST_NONE) ||
      (status_o == ST_ACK)))
    else $error("undefined status code");

endmodule

bind free_cell_reach_and_path fcrp_checker u_fcrp_checker (.*);
`default_nettype wire

@@ tb/sv/free_cell_reach_and_path_chk.sv @@
// Checker for the cell walk block: snoops the channels, predicts result words and compares.
module free_cell_reach_and_path_chk import fcrp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        action_i,
  input  logic [CELL_W-1:0] cell_req_i,
  input  logic [1:0]        slot_i,
  input  logic [CELL_W-1:0] neighbour_cell_i,
  input  logic              flag_i,
  input  logic [CELL_W-1:0] target_cell_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CELL_W-1:0] cell_out_i,
  input  logic [1:0]        status_i,
  input  logic              last_i,
  output int                pending_o,
  output int                fails_o
);

  typedef struct {
    logic [CELL_W-1:0] cell_val;
    status_e           status;
    logic              last;
  } word_t;

  word_t             want_q[$];
  logic [5:0]        nbr_tbl [TBL_DEPTH];
  logic [NODES-1:0]  occ;
  logic [NODES-1:0]  seen;
  logic [4:0]        parent [NODES];
  logic [4:0]        stk_cell [STACK_CAP];
  int                stk_slot [STACK_CAP];
  int                sp;
  logic [CFG_W-1:0]  live_reg;
  int                fails;

  function automatic int live_n();
    if (live_reg < 1) return 1;
    if (live_reg > NODES) return NODES;
    return int'(live_reg);
  endfunction

  function automatic void push_frame(logic [4:0] c);
    if (sp < STACK_CAP) begin
      stk_cell[sp] = c;
      stk_slot[sp] = 0;
      sp++;
    end
  endfunction

  // Advance the top frame one slot; -1 when the slot is empty or dangling.
  function automatic int next_nb(int n, output logic [4:0] from);
    int         top;
    logic [5:0] e;
    top = sp - 1;
    from = stk_cell[top];
    e = nbr_tbl[stk_cell[top] * MAX_DEG + stk_slot[top]];
    stk_slot[top]++;
    if (!e[5] || e[4:0] >= n) return -1;
    return int'(e[4:0]);
  endfunction

  function automatic void add_word(logic [4:0] c, status_e st, logic l);
    word_t w;
    w.cell_val = c;
    w.status = st;
    w.last = l;
    want_q.insert(want_q.size(), w);
  endfunction

  // Free-cell preorder walk; fills reach list, returns count.
  function automatic int reach_walk(logic [4:0] start, int n, ref logic [4:0] lst [NODES]);
    int         cnt;
    int         nb;
    logic [4:0] from;
    cnt = 0;
    seen = '0;
    sp = 0;
    push_frame(start);
    while (sp > 0) begin
      if (stk_slot[sp-1] >= MAX_DEG) begin
        sp--;
        continue;
      end
      nb = next_nb(n, from);
      if (nb < 0) continue;
      if (occ[nb] || seen[nb]) continue;
      seen[nb] = 1'b1;
      if (cnt < NODES) begin
        lst[cnt] = nb[4:0];
        cnt++;
      end
      push_frame(nb[4:0]);
    end
    return cnt;
  endfunction

  // Parent-recording walk; occupied cells other than the start are leaves.
  function automatic void parent_walk(logic [4:0] start, int n);
    int         nb;
    logic [4:0] from;
    seen = '0;
    sp = 0;
    seen[start] = 1'b1;
    parent[start] = start;
    push_frame(start);
    while (sp > 0) begin
      if (stk_slot[sp-1] >= MAX_DEG) begin
        sp--;
        continue;
      end
      nb = next_nb(n, from);
      if (nb < 0 || seen[nb]) continue;
      seen[nb] = 1'b1;
      parent[nb] = from;
      if (occ[nb] && nb != start) continue;
      push_frame(nb[4:0]);
    end
  endfunction

  function automatic void predict_word();
    int         n;
    int         cnt;
    logic [4:0] lst [NODES];
    logic [4:0] path [NODES];
    logic [4:0] c;
    n = live_n();
    case (action_e'(action_i))
      ACT_WR_SLOT: begin
        if (cell_req_i < n && slot_i < MAX_DEG)
          nbr_tbl[cell_req_i * MAX_DEG + slot_i] = {flag_i, neighbour_cell_i};
        add_word('0, ST_ACK, 1'b1);
      end
      ACT_SET_OCC: begin
        if (cell_req_i < n) occ[cell_req_i] = flag_i;
        add_word('0, ST_ACK, 1'b1);
      end
      default: begin
        if (cell_req_i >= n) begin
          add_word('0, ST_NONE, 1'b1);
        end else begin
          cnt = reach_walk(cell_req_i, n, lst);
          if (action_e'(action_i) == ACT_LIST) begin
            if (cnt == 0) add_word('0, ST_NONE, 1'b1);
            for (int k = 0; k < cnt; k++) add_word(lst[k], ST_CELL, k + 1 == cnt);
          end else if (target_cell_i >= n || target_cell_i == cell_req_i
                       || !seen[target_cell_i]) begin
            add_word('0, ST_NONE, 1'b1);
          end else begin
            occ[target_cell_i] = 1'b1;
            parent_walk(cell_req_i, n);
            cnt = 0;
            c = target_cell_i;
            while (c != cell_req_i && cnt < NODES) begin
              path[cnt] = c;
              cnt++;
              c = parent[c];
            end
            occ[cell_req_i] = 1'b0;
            for (int k = 0; k < cnt; k++) add_word(path[cnt-1-k], ST_CELL, k + 1 == cnt);
          end
        end
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_t w;
    if (!rst_ni) begin
      for (int i = 0; i < TBL_DEPTH; i++) nbr_tbl[i] = '0;
      occ = '0;
      seen = '0;
      sp = 0;
      live_reg = 6'd32;
      fails = 0;
      want_q.delete();
      pending_o <= 0;
      fails_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (want_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected word: cell %0d status %0d last %0d",
                     cell_out_i, status_i, last_i);
        end else begin
          w = want_q.pop_front();
          if (cell_out_i !== w.cell_val || status_i !== w.status || last_i !== w.last) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: want cell %0d status %0d last %0d, got %0d %0d %0d",
                       w.cell_val, w.status, w.last, cell_out_i, status_i, last_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_word();
      if (cfg_we_i) live_reg = cfg_wdata_i;
      pending_o <= want_q.size();
      fails_o <= fails;
    end
  end

endmodule

@@ tb/sv/free_cell_reach_and_path_tb.sv @@
// Testbench top for the cell walk block: clock, reset, stimulus and verdict.
module free_cell_reach_and_path_tb;
  import fcrp_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        action_i = '0;
  logic [CELL_W-1:0] cell_req_i = '0;
  logic [1:0]        slot_i = '0;
  logic [CELL_W-1:0] neighbour_cell_i = '0;
  logic              flag_i = 1'b0;
  logic [CELL_W-1:0] target_cell_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CELL_W-1:0] cell_out_o;
  logic [1:0]        status_o;
  logic              last_o;
  int                pending;
  int                fails;

  bit                gaps_on = 1'b1;
  bit                hold_req = 1'b0;
  int                hold_left = 0;
  int                burst = 0;
  int                cycles = 0;
  int                n_cur = 32;
  int                sent = 0;

  free_cell_reach_and_path dut (.*);

  free_cell_reach_and_path_chk chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .action_i, .cell_req_i, .slot_i,
    .neighbour_cell_i, .flag_i, .target_cell_i,
    .out_valid_i(out_valid_o), .out_ready_i, .cell_out_i(cell_out_o),
    .status_i(status_o), .last_i(last_o), .pending_o(pending), .fails_o(fails)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!gaps_on) begin
      out_ready_i <= 1'b1;
    end else if (burst > 0) begin
      burst--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      burst = $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Valid stays high between back-to-back words; lowered only for gaps and drains.
  task automatic send(logic [1:0] a, logic [4:0] c, logic [1:0] s, logic [4:0] nb,
                      logic f, logic [4:0] t);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= a;
    cell_req_i <= c;
    slot_i <= s;
    neighbour_cell_i <= nb;
    flag_i <= f;
    target_cell_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_live(logic [CFG_W-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (v < 1) n_cur = 1;
    else if (v > NODES) n_cur = NODES;
    else n_cur = v;
  endtask

  function automatic logic [4:0] pick();
    if ($urandom_range(0, 15) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, n_cur - 1));
  endfunction

  task automatic rand_word(bit build);
    int k;
    k = $urandom_range(0, 99);
    if (k < 5)
      send(2'($urandom), 5'($urandom), 2'($urandom), 5'($urandom), 1'($urandom),
           5'($urandom));
    else if (build || k < 30)
      send(ACT_WR_SLOT, pick(), 2'($urandom), pick(), $urandom_range(0, 5) != 0, pick());
    else if (k < 42)
      send(ACT_SET_OCC, pick(), 2'($urandom), pick(), $urandom_range(0, 2) == 0, pick());
    else if (k < 66)
      send(ACT_LIST, pick(), 2'($urandom), pick(), 1'($urandom), pick());
    else
      send(ACT_MOVE, pick(), 2'($urandom), pick(), 1'($urandom), pick());
  endtask

  initial begin
    int sizes [14] = '{4, 8, 3, 16, 32, 6, 0, 12, 5, 63, 10, 2, 20, 7};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty graph, chains, self loop, invalid and dangling entries, occupancy
    send(ACT_LIST, 5'd0, 2'd0, 5'd0, 1'b0, 5'd0);
    send(ACT_WR_SLOT, 5'd0, 2'd0, 5'd1, 1'b1, 5'd0);
    send(ACT_WR_SLOT, 5'd1, 2'd1, 5'd2, 1'b1, 5'd0);
    send(ACT_WR_SLOT, 5'd2, 2'd3, 5'd31, 1'b1, 5'd0);
    send(ACT_WR_SLOT, 5'd31, 2'd3, 5'd0, 1'b1, 5'd31);
    send(ACT_WR_SLOT, 5'd31, 2'd2, 5'd31, 1'b1, 5'd0);
    send(ACT_WR_SLOT, 5'd1, 2'd2, 5'd30, 1'b0, 5'd0);
    send(ACT_LIST, 5'd0, 2'd0, 5'd0, 1'b0, 5'd0);
    send(ACT_MOVE, 5'd0, 2'd0, 5'd0, 1'b0, 5'd31);
    send(ACT_MOVE, 5'd31, 2'd0, 5'd0, 1'b0, 5'd31);
    send(ACT_MOVE, 5'd31, 2'd0, 5'd0, 1'b0, 5'd7);
    send(ACT_SET_OCC, 5'd2, 2'd0, 5'd0, 1'b1, 5'd0);
    send(ACT_LIST, 5'd0, 2'd0, 5'd0, 1'b0, 5'd0);
    send(ACT_MOVE, 5'd0, 2'd0, 5'd0, 1'b0, 5'd1);
    send(ACT_SET_OCC, 5'd2, 2'd0, 5'd0, 1'b0, 5'd0);
    send(ACT_SET_OCC, 5'd31, 2'd3, 5'd31, 1'b1, 5'd31);
    set_live(6'd0);
    send(ACT_LIST, 5'd0, 2'd0, 5'd0, 1'b0, 5'd0);
    send(ACT_LIST, 5'd5, 2'd0, 5'd0, 1'b0, 5'd0);
    send(ACT_WR_SLOT, 5'd3, 2'd1, 5'd0, 1'b1, 5'd0);
    send(ACT_MOVE, 5'd0, 2'd0, 5'd0, 1'b0, 5'd0);
    set_live(6'd3);
    send(ACT_WR_SLOT, 5'd0, 2'd0, 5'd9, 1'b1, 5'd0);
    send(ACT_LIST, 5'd0, 2'd0, 5'd0, 1'b0, 5'd0);

    for (int ph = 0; ph < 14; ph++) begin
      set_live(6'(sizes[ph]));
      if (ph >= 12) gaps_on = 1'b0;
      if (ph == 3) hold_req = 1'b1;
      for (int i = 0; i < 26; i++) rand_word(i < n_cur && i < 10);
      if (ph == 7) drain();
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/fcrp_pkg.sv
hw/rtl/fcrp_ram.sv
hw/rtl/fcrp_ctrl.sv
hw/rtl/fcrp_dp.sv
hw/rtl/free_cell_reach_and_path.sv
hw/rtl/fcrp_checker.sv
tb/sv/free_cell_reach_and_path_chk.sv
tb/sv/free_cell_reach_and_path_tb.sv
